/* hdl/cps_pkg.sv */
// Shared types and constants for the critical path scheduler.
// Used by cps_ctrl, cps_dp and critical_path_scheduler_core.
`default_nettype none
package cps_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 32;
  localparam int OUT_LIMIT        = 48;
  localparam int CNT_W            = 5;   // vertex_count register width
  localparam int IDX_W            = 4;   // vertex index field width
  localparam int WGT_W            = 16;
  localparam int EAR_W            = 20;
  localparam int LAT_W            = 21;
  localparam int RES_W            = 6;

  localparam logic [EAR_W-1:0]        EARLY_MAX  = 20'hFFFFF;
  localparam logic signed [LAT_W-1:0] LATE_MIN   = -21'sd1048576;
  localparam logic signed [LAT_W:0]   LATE_MIN_X = -22'sd1048576;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;
  localparam logic KIND_VTX  = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RC_ADDR, ST_RC_EXEC, ST_SCAN, ST_POP, ST_TP_ADDR, ST_TP_EXEC,
    ST_LAT_INIT, ST_RPOP, ST_RV_ADDR, ST_RV_EXEC, ST_EMIT_V, ST_EE_ADDR,
    ST_EE_EXEC, ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RUN_INIT, OP_RC_COUNT, OP_SCAN, OP_POP, OP_TOPO_EDGE,
    OP_LAT_INIT, OP_RPOP, OP_REV_EDGE, OP_EMIT_V, OP_EE_BEGIN, OP_EE_NEXT,
    OP_EMIT_EDGE, OP_FLUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic e_zero;       // edge walk finished
    logic vtx_end;      // vertex index reached vertex_count
    logic stack_empty;  // ready stack empty
    logic order_empty;  // reverse walk over sorted order finished
    logic slot_free;    // output register can take a transfer
  } stat_t;

  typedef struct packed {
    logic                    last;
    logic                    drop;
    logic                    cyc;
    logic [WGT_W-1:0]        dur;
    logic signed [LAT_W-1:0] late;
    logic [EAR_W-1:0]        early;
    logic [IDX_W-1:0]        to_v;
    logic [IDX_W-1:0]        from_v;
    logic                    kind;
  } res_t;

endpackage
`default_nettype wire

/* hdl/cps_ctrl.sv */
// Sequencer for the critical path scheduler: load, recount, sort, reverse pass, emit.
// Depends on cps_pkg; drives cps_dp through cmd_t and watches stat_t.
`default_nettype none
module cps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_mode_i,
  output logic               in_ready_o,
  input  wire cps_pkg::stat_t stat_i,
  output cps_pkg::cmd_t      cmd_o
);
  import cps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == MODE_RUN) begin
            cmd_o.op = OP_RUN_INIT;
            state_d  = ST_RC_ADDR;
          end else begin
            cmd_o.op = OP_LOAD;
          end
        end
      end
      ST_RC_ADDR:  state_d = stat_i.e_zero ? ST_SCAN : ST_RC_EXEC;
      ST_RC_EXEC: begin
        cmd_o.op = OP_RC_COUNT;
        state_d  = ST_RC_ADDR;
      end
      ST_SCAN: begin
        if (stat_i.vtx_end) state_d = ST_POP;
        else cmd_o.op = OP_SCAN;
      end
      ST_POP: begin
        if (stat_i.stack_empty) begin
          state_d = ST_LAT_INIT;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = ST_TP_ADDR;
        end
      end
      ST_TP_ADDR:  state_d = stat_i.e_zero ? ST_POP : ST_TP_EXEC;
      ST_TP_EXEC: begin
        cmd_o.op = OP_TOPO_EDGE;
        state_d  = ST_TP_ADDR;
      end
      ST_LAT_INIT: begin
        cmd_o.op = OP_LAT_INIT;
        state_d  = ST_RPOP;
      end
      ST_RPOP: begin
        if (stat_i.order_empty) begin
          state_d = ST_EMIT_V;
        end else begin
          cmd_o.op = OP_RPOP;
          state_d  = ST_RV_ADDR;
        end
      end
      ST_RV_ADDR:  state_d = stat_i.e_zero ? ST_RPOP : ST_RV_EXEC;
      ST_RV_EXEC: begin
        cmd_o.op = OP_REV_EDGE;
        state_d  = ST_RV_ADDR;
      end
      ST_EMIT_V: begin
        if (stat_i.vtx_end) begin
          cmd_o.op = OP_EE_BEGIN;
          state_d  = ST_EE_ADDR;
        end else if (stat_i.slot_free) begin
          cmd_o.op = OP_EMIT_V;
        end
      end
      ST_EE_ADDR: begin
        if (stat_i.vtx_end) state_d = ST_FINISH;
        else if (stat_i.e_zero) cmd_o.op = OP_EE_NEXT;
        else state_d = ST_EE_EXEC;
      end
      ST_EE_EXEC: begin
        // hold the edge until the output side can take a transfer
        if (stat_i.slot_free) begin
          cmd_o.op = OP_EMIT_EDGE;
          state_d  = ST_EE_ADDR;
        end
      end
      ST_FINISH: begin
        if (stat_i.slot_free) begin
          cmd_o.op = OP_FLUSH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EE_EXEC && !stat_i.slot_free) |=> state_q == ST_EE_EXEC)
    else $error("edge emission left while output stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FLUSH) |=> state_q == ST_IDLE)
    else $error("flush did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i && in_mode_i == MODE_LOAD) |=> state_q == ST_IDLE)
    else $error("edge load left idle");

endmodule
`default_nettype wire

/* hdl/cps_dp.sv */
// Datapath: edge store, vertex time registers, stacks, counters and output registers.
// Depends on cps_pkg; commanded by cps_ctrl.
`default_nettype none
module cps_dp #(
  parameter int MaxVertices = cps_pkg::MAX_VERTICES_DEF,
  parameter int MaxEdges    = cps_pkg::MAX_EDGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cps_pkg::cmd_t               cmd_i,
  output cps_pkg::stat_t                   stat_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [cps_pkg::CNT_W-1:0]   cfg_data_i,
  input  wire logic [cps_pkg::IDX_W-1:0]   ld_src_i,
  input  wire logic [cps_pkg::IDX_W-1:0]   ld_tgt_i,
  input  wire logic [cps_pkg::WGT_W-1:0]   ld_wgt_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output cps_pkg::res_t                    out_o
);
  import cps_pkg::*;

  localparam int VW  = $clog2(MaxVertices);
  localparam int EW  = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int ECW = $clog2(MaxEdges + 1);
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MaxVertices);

  // edge store
  logic [IDX_W-1:0] tail_mem [MaxEdges];
  logic [IDX_W-1:0] head_mem [MaxEdges];
  logic [WGT_W-1:0] wgt_mem  [MaxEdges];
  logic [IDX_W-1:0] rd_tail_q, rd_head_q;
  logic [WGT_W-1:0] rd_wgt_q;

  // vertex state
  logic [EAR_W-1:0]        ear_q   [MaxVertices];
  logic signed [LAT_W-1:0] lat_q   [MaxVertices];
  logic [ECW-1:0]          indeg_q [MaxVertices];
  logic [VW-1:0]           ready_q [MaxVertices];
  logic [VW-1:0]           order_q [MaxVertices];

  logic [CNT_W-1:0]        n_q;
  logic [ECW-1:0]          edges_q, e_idx_q;
  logic                    drop_q, cyc_q;
  logic [CNT_W-1:0]        v_idx_q, top_q, cnt_q, i_idx_q;
  logic [VW-1:0]           v_q;
  logic [EAR_W-1:0]        ev_q;
  logic signed [LAT_W-1:0] lv_q;
  logic [RES_W-1:0]        res_q;
  logic                    out_v_q, pend_v_q;
  res_t                    out_q, pend_q;

  logic [EW-1:0]           rd_addr;
  logic [ECW-1:0]          e_dec;
  logic [VW-1:0]           k, ear_addr, lat_addr, top_m1, ord_m1, pop_v, rpop_v;
  logic [EAR_W-1:0]        ear_rd;
  logic signed [LAT_W-1:0] lat_rd, lk;
  logic                    edge_hit, ld_ok, take, slot_free, emit_en, res_room;
  logic [EAR_W:0]          s_sum;
  logic [EAR_W-1:0]        s_sat;
  logic signed [LAT_W:0]   c_dif;
  logic signed [LAT_W-1:0] c_sat;
  logic [CNT_W-1:0]        cfg_clamped;
  res_t                    new_res;

  assign e_dec    = e_idx_q - ECW'(1);
  assign rd_addr  = e_dec[EW-1:0];
  assign k        = rd_head_q[VW-1:0];
  assign edge_hit = ({1'b0, rd_tail_q} == CNT_W'(v_q)) && ({1'b0, rd_head_q} < n_q);
  assign top_m1   = VW'(top_q - CNT_W'(1));
  assign ord_m1   = VW'(i_idx_q - CNT_W'(1));
  assign pop_v    = ready_q[top_m1];
  assign rpop_v   = order_q[ord_m1];
  assign ld_ok    = ({1'b0, ld_src_i} < n_q) && ({1'b0, ld_tgt_i} < n_q)
                    && (edges_q < ECW'(MaxEdges));
  assign take      = out_v_q && out_ready_i;
  assign slot_free = !out_v_q || out_ready_i;
  assign res_room  = res_q < RES_W'(OUT_LIMIT);

  always_comb begin
    cfg_clamped = cfg_data_i;
    if (cfg_data_i == '0) cfg_clamped = CNT_W'(1);
    else if (cfg_data_i > NMAX) cfg_clamped = NMAX;
  end

  // one read select per time array
  always_comb begin
    ear_addr = k;
    lat_addr = k;
    unique case (cmd_i.op)
      OP_POP:       ear_addr = pop_v;
      OP_LAT_INIT:  ear_addr = VW'(n_q - CNT_W'(1));
      OP_RPOP:      lat_addr = rpop_v;
      OP_EMIT_V: begin
        ear_addr = v_idx_q[VW-1:0];
        lat_addr = v_idx_q[VW-1:0];
      end
      OP_EMIT_EDGE: ear_addr = v_idx_q[VW-1:0];
      default:      ear_addr = k;
    endcase
  end
  assign ear_rd = ear_q[ear_addr];
  assign lat_rd = lat_q[lat_addr];

  // longest-path relaxation and latest-time relaxation
  assign s_sum = {1'b0, ev_q} + (EAR_W+1)'(rd_wgt_q);
  assign s_sat = s_sum[EAR_W] ? EARLY_MAX : s_sum[EAR_W-1:0];
  assign lk    = ((cmd_i.op == OP_REV_EDGE) && (k == v_q)) ? lv_q : lat_rd;
  assign c_dif = {lk[LAT_W-1], lk} - $signed({{(LAT_W+1-WGT_W){1'b0}}, rd_wgt_q});
  assign c_sat = (c_dif < LATE_MIN_X) ? LATE_MIN : c_dif[LAT_W-1:0];

  always_comb begin
    new_res        = '0;
    new_res.cyc    = cyc_q;
    new_res.drop   = drop_q;
    new_res.from_v = IDX_W'(v_idx_q[VW-1:0]);
    emit_en        = 1'b0;
    if (cmd_i.op == OP_EMIT_V) begin
      new_res.kind  = KIND_VTX;
      new_res.early = ear_rd;
      new_res.late  = lat_rd;
      emit_en       = res_room;
    end else if (cmd_i.op == OP_EMIT_EDGE) begin
      new_res.kind = KIND_EDGE;
      new_res.to_v = rd_head_q;
      new_res.dur  = rd_wgt_q;
      emit_en      = res_room && ({1'b0, rd_tail_q} == v_idx_q)
                     && ({1'b0, rd_head_q} < n_q)
                     && ({2'b00, ear_rd} == c_dif);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && ld_ok) begin
      tail_mem[edges_q[EW-1:0]] <= ld_src_i;
      head_mem[edges_q[EW-1:0]] <= ld_tgt_i;
      wgt_mem[edges_q[EW-1:0]]  <= ld_wgt_i;
    end
    rd_tail_q <= tail_mem[rd_addr];
    rd_head_q <= head_mem[rd_addr];
    rd_wgt_q  <= wgt_mem[rd_addr];
  end

  // vertex arrays: cleared by the run itself
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_RUN_INIT: begin
        for (int i = 0; i < MaxVertices; i++) begin
          indeg_q[i] <= '0;
          ear_q[i]   <= '0;
        end
      end
      OP_RC_COUNT: begin
        if (({1'b0, rd_tail_q} < n_q) && ({1'b0, rd_head_q} < n_q))
          indeg_q[k] <= indeg_q[k] + ECW'(1);
      end
      OP_SCAN: begin
        if (indeg_q[v_idx_q[VW-1:0]] == '0) ready_q[VW'(top_q)] <= v_idx_q[VW-1:0];
      end
      OP_POP: begin
        if (cnt_q < NMAX) order_q[VW'(cnt_q)] <= pop_v;
      end
      OP_TOPO_EDGE: begin
        if (edge_hit) begin
          if (indeg_q[k] != '0) begin
            indeg_q[k] <= indeg_q[k] - ECW'(1);
            if (indeg_q[k] == ECW'(1) && top_q < NMAX) ready_q[VW'(top_q)] <= k;
          end
          if (s_sat > ear_rd) ear_q[k] <= s_sat;
        end
      end
      OP_LAT_INIT: begin
        for (int i = 0; i < MaxVertices; i++) begin
          if (CNT_W'(i) < n_q) lat_q[i] <= $signed({1'b0, ear_rd});
        end
      end
      OP_REV_EDGE: begin
        if (edge_hit && c_sat < lv_q) lat_q[v_q] <= c_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= NMAX;
      edges_q  <= '0;
      drop_q   <= 1'b0;
      cyc_q    <= 1'b0;
      e_idx_q  <= '0;
      v_idx_q  <= '0;
      top_q    <= '0;
      cnt_q    <= '0;
      i_idx_q  <= '0;
      v_q      <= '0;
      ev_q     <= '0;
      lv_q     <= '0;
      res_q    <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) n_q <= cfg_clamped;
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (ld_ok) edges_q <= edges_q + ECW'(1);
          else drop_q <= 1'b1;
        end
        OP_RUN_INIT: begin
          e_idx_q <= edges_q;
          v_idx_q <= '0;
          top_q   <= '0;
          cnt_q   <= '0;
          res_q   <= '0;
        end
        OP_RC_COUNT: e_idx_q <= e_dec;
        OP_SCAN: begin
          if (indeg_q[v_idx_q[VW-1:0]] == '0) top_q <= top_q + CNT_W'(1);
          v_idx_q <= v_idx_q + CNT_W'(1);
        end
        OP_POP: begin
          top_q   <= top_q - CNT_W'(1);
          if (cnt_q < NMAX) cnt_q <= cnt_q + CNT_W'(1);
          v_q     <= pop_v;
          ev_q    <= ear_rd;
          e_idx_q <= edges_q;
        end
        OP_TOPO_EDGE: begin
          if (edge_hit) begin
            if (indeg_q[k] == ECW'(1) && top_q < NMAX) top_q <= top_q + CNT_W'(1);
            // self loop: keep the cached tail time in step
            if (s_sat > ear_rd && k == v_q) ev_q <= s_sat;
          end
          e_idx_q <= e_dec;
        end
        OP_LAT_INIT: begin
          cyc_q   <= cnt_q < n_q;
          i_idx_q <= cnt_q;
          v_idx_q <= '0;
        end
        OP_RPOP: begin
          i_idx_q <= i_idx_q - CNT_W'(1);
          v_q     <= rpop_v;
          lv_q    <= lat_rd;
          e_idx_q <= edges_q;
        end
        OP_REV_EDGE: begin
          if (edge_hit && c_sat < lv_q) lv_q <= c_sat;
          e_idx_q <= e_dec;
        end
        OP_EMIT_V:    v_idx_q <= v_idx_q + CNT_W'(1);
        OP_EE_BEGIN: begin
          v_idx_q <= '0;
          e_idx_q <= edges_q;
        end
        OP_EE_NEXT: begin
          v_idx_q <= v_idx_q + CNT_W'(1);
          e_idx_q <= edges_q;
        end
        OP_EMIT_EDGE: e_idx_q <= e_dec;
        OP_FLUSH: begin
          edges_q <= '0;
          drop_q  <= 1'b0;
        end
        default: ;
      endcase

      // the newest result is held in a pending register so the final one can carry tlast
      if (cmd_i.op == OP_FLUSH) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (emit_en) begin
        res_q    <= res_q + RES_W'(1);
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
        else if (take) out_v_q <= 1'b0;
      end else if (take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FLUSH) begin
      out_q      <= pend_q;
      out_q.last <= 1'b1;
    end else if (emit_en) begin
      if (pend_v_q) out_q <= pend_q;
      pend_q <= new_res;
    end
  end

  always_comb begin
    stat_o.e_zero      = e_idx_q == '0;
    stat_o.vtx_end     = v_idx_q == n_q;
    stat_o.stack_empty = top_q == '0;
    stat_o.order_empty = i_idx_q == '0;
    stat_o.slot_free   = slot_free;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FLUSH) |-> pend_v_q)
    else $error("flush without a pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FLUSH) |=> (edges_q == '0 && !drop_q))
    else $error("edge store not cleared after run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q <= RES_W'(OUT_LIMIT))
    else $error("result count beyond limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= NMAX && cnt_q <= NMAX)
    else $error("stack pointer out of range");

endmodule
`default_nettype wire

/* hdl/critical_path_scheduler_core.sv */
// Channel      | dir | tdata (low bit up)                                  | tuser | tlast
// s_axis       | in  | edge_source, edge_target, edge_weight (24b)         | mode  | -
// m_axis       | out | from, to, earliest, latest, duration, cycle, drop   | kind  | last_result
// cfg_wr       | in  | vertex_count (5b), no index, written when cfg_wr_en_i is high
// Edge loads keep the sequencer idle, so a new edge can follow straight after the last one.
// A run recounts in-degrees, sorts, walks back over the sorted order and then emits;
// the sequencer walks the single-port edge store with an address state and an execute state
// per edge.
// Reset clears control state and sets vertex_count to its maximum; a stalled m_axis holds
// the sequencer at the next result. Input is taken again once the run's last result is
// registered, and the next run's first result waits for that final transfer.
`default_nettype none
module critical_path_scheduler_core #(
  parameter int MaxVertices = cps_pkg::MAX_VERTICES_DEF,
  parameter int MaxEdges    = cps_pkg::MAX_EDGES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [4:0]  cfg_wr_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // edge_source[3:0], edge_target[7:4], edge_weight[23:8]
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // from[3:0], to[7:4], earliest[27:8], latest[48:28],
                                           // duration[64:49], cycle_found[65], edge_dropped[66]
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast    // last_result
);
  import cps_pkg::*;

  cmd_t cmd;
  stat_t stat;
  res_t res;

  cps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cps_dp #(
    .MaxVertices (MaxVertices),
    .MaxEdges    (MaxEdges)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_data_i  (cfg_wr_data_i),
    .ld_src_i    (s_axis_tdata[3:0]),
    .ld_tgt_i    (s_axis_tdata[7:4]),
    .ld_wgt_i    (s_axis_tdata[23:8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {5'b0, res.drop, res.cyc, res.dur, res.late, res.early,
                         res.to_v, res.from_v};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
